>>> src/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types, character codes and helpers for the printf-style formatter.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int unsigned CountW   = 32;
  localparam int unsigned ArgW     = 64;
  localparam int unsigned StackD   = 16;
  localparam int unsigned SpW      = $clog2(StackD) + 1;

  localparam logic [32:0] Recip10  = 33'h0_CCCC_CCCD;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] SelC      = 8'h63;
  localparam logic [7:0] SelD      = 8'h64;
  localparam logic [7:0] SelI      = 8'h69;
  localparam logic [7:0] SelU      = 8'h75;
  localparam logic [7:0] SelX      = 8'h78;
  localparam logic [7:0] SelUpX    = 8'h58;
  localparam logic [7:0] SelP      = 8'h70;

  typedef enum logic [2:0] {
    K_NONE,
    K_CHAR,
    K_DEC,
    K_UDEC,
    K_HEXL,
    K_HEXU,
    K_PTR
  } kind_e;

  typedef enum logic [1:0] {
    P_NONE,
    P_MINUS,
    P_HEX0X
  } pre_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_GEN,
    S_PRE,
    S_POP
  } st_e;

  typedef struct packed {
    kind_e            kind;
    logic             clr;
    logic [7:0]       ch;
    logic [ArgW-1:0]  arg;
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? ChUpA : ChLowA;
    if (d < 4'd10) begin
      digit_char = ChZero + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

>>> src/psf_front.sv
// ----------------------------------------------------------------------------
// psf_front
// Accepts format bytes, tracks the pending '%', and turns each byte that emits
// output or starts a format into a command for the back end.
// ----------------------------------------------------------------------------
module psf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              q_full_i,
  input  logic [7:0]        fmt_byte_i,
  input  logic [63:0]       arg_value_i,
  input  logic              first_of_format_i,
  output logic              q_push_o,
  output psf_pkg::cmd_t     q_cmd_o
);
  import psf_pkg::*;

  logic  pending_q, pending_d;
  logic  accept;
  kind_e kind;
  logic [7:0] ch;

  assign accept = push_i && !q_full_i;

  always_comb begin
    pending_d = pending_q;
    kind      = K_NONE;
    ch        = fmt_byte_i;
    if (accept) begin
      if (fmt_byte_i == ChNul) begin
        pending_d = 1'b0;
      end else if (pending_q) begin
        pending_d = 1'b0;
        unique case (fmt_byte_i)
          SelC: begin
            kind = K_CHAR;
            ch   = arg_value_i[7:0];
          end
          SelD, SelI: kind = K_DEC;
          SelU:       kind = K_UDEC;
          SelX:       kind = K_HEXL;
          SelUpX:     kind = K_HEXU;
          SelP:       kind = K_PTR;
          ChPercent:  kind = K_CHAR;
          default:    kind = K_NONE;
        endcase
      end else if (fmt_byte_i == ChPercent) begin
        pending_d = 1'b1;
      end else begin
        kind = K_CHAR;
      end
    end
  end

  assign q_cmd_o.kind = kind;
  assign q_cmd_o.clr  = first_of_format_i;
  assign q_cmd_o.ch   = ch;
  assign q_cmd_o.arg  = arg_value_i;
  assign q_push_o     = accept && (kind != K_NONE || first_of_format_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

>>> src/psf_cmd_queue.sv
// ----------------------------------------------------------------------------
// psf_cmd_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module psf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output psf_pkg::cmd_t data_o
);
  import psf_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> src/psf_back.sv
// ----------------------------------------------------------------------------
// psf_back
// Executes commands: generates digits one per cycle onto a digit stack, then
// emits prefix and digits through a one-entry output register.
// ----------------------------------------------------------------------------
module psf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  psf_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_char_o,
  output logic          last_of_run_o,
  output logic [31:0]   emitted_total_o
);
  import psf_pkg::*;

  st_e                state_q, state_d;
  logic [ArgW-1:0]    val_q, val_d;
  logic               hex_q, hex_d;
  logic               upper_q, upper_d;
  pre_e               pre_q, pre_d;
  logic               pidx_q, pidx_d;
  logic [7:0]         ch_q, ch_d;
  logic [SpW-1:0]     sp_q, sp_d;
  logic [CountW-1:0]  count_q, count_d, count_inc;
  logic [3:0]         stk_q [StackD];

  logic               oval_q, oval_d;
  logic [7:0]         ochar_q;
  logic               olast_q;
  logic [CountW-1:0]  ototal_q;

  logic               can_emit, emit, emit_last;
  logic [7:0]         emit_char;
  logic               stk_we;
  logic [3:0]         digit;
  logic [ArgW-1:0]    nxt;
  logic [64:0]        prod;
  logic [28:0]        quo;
  logic [31:0]        quo10, rem;
  logic [SpW-1:0]     sp_top;

  assign can_emit  = !oval_q || pop_i;
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign sp_top    = sp_q - 1'b1;

  // divide by ten via reciprocal
  assign prod  = {33'b0, val_q[31:0]} * {32'b0, Recip10};
  assign quo   = prod[63:35];
  assign quo10 = {quo[28:0], 3'b0} + {2'b0, quo[28:0], 1'b0};
  assign rem   = val_q[31:0] - quo10;
  assign digit = hex_q ? val_q[3:0] : rem[3:0];
  assign nxt   = hex_q ? {4'b0, val_q[ArgW-1:4]} : {35'b0, quo};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_cmd_i.kind)
            K_CHAR:                             state_d = S_CHAR;
            K_DEC, K_UDEC, K_HEXL, K_HEXU, K_PTR: state_d = S_GEN;
            default:                            state_d = S_IDLE;
          endcase
        end
      end
      S_CHAR: begin
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      S_GEN: begin
        if (nxt == '0) begin
          state_d = (pre_q == P_NONE) ? S_POP : S_PRE;
        end
      end
      S_PRE: begin
        if (can_emit && (pre_q == P_MINUS || pidx_q)) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (can_emit && sp_q == SpW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    val_d     = val_q;
    hex_d     = hex_q;
    upper_d   = upper_q;
    pre_d     = pre_q;
    pidx_d    = pidx_q;
    ch_d      = ch_q;
    sp_d      = sp_q;
    count_d   = count_q;
    q_pop_o   = 1'b0;
    stk_we    = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = ch_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.clr) begin
            count_d = '0;
          end
          ch_d    = q_cmd_i.ch;
          sp_d    = '0;
          pidx_d  = 1'b0;
          pre_d   = P_NONE;
          hex_d   = 1'b1;
          upper_d = 1'b0;
          val_d   = {32'b0, q_cmd_i.arg[31:0]};
          unique case (q_cmd_i.kind)
            K_DEC: begin
              hex_d = 1'b0;
              if (q_cmd_i.arg[31]) begin
                pre_d = P_MINUS;
                val_d = {32'b0, 32'd0 - q_cmd_i.arg[31:0]};
              end
            end
            K_UDEC:  hex_d = 1'b0;
            K_HEXU:  upper_d = 1'b1;
            K_PTR: begin
              pre_d = P_HEX0X;
              val_d = q_cmd_i.arg;
            end
            default: ;
          endcase
        end
      end
      S_CHAR: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_char = ch_q;
        end
      end
      S_GEN: begin
        stk_we = 1'b1;
        sp_d   = sp_q + 1'b1;
        val_d  = nxt;
      end
      S_PRE: begin
        if (can_emit) begin
          emit = 1'b1;
          if (pre_q == P_MINUS) begin
            emit_char = ChMinus;
          end else begin
            emit_char = pidx_q ? ChLowX : ChZero;
            pidx_d    = 1'b1;
          end
        end
      end
      S_POP: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = (sp_q == SpW'(1));
          emit_char = digit_char(stk_q[sp_top[SpW-2:0]], upper_q);
          sp_d      = sp_top;
        end
      end
      default: ;
    endcase
    if (emit) begin
      count_d = count_inc;
    end
  end

  always_comb begin
    oval_d = oval_q;
    if (emit) begin
      oval_d = 1'b1;
    end else if (pop_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_q[sp_q[SpW-2:0]] <= digit;
    end
    if (emit) begin
      ochar_q  <= emit_char;
      olast_q  <= emit_last;
      ototal_q <= count_inc;
    end
    val_q   <= val_d;
    hex_q   <= hex_d;
    upper_q <= upper_d;
    pre_q   <= pre_d;
    pidx_q  <= pidx_d;
    ch_q    <= ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      count_q <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      count_q <= count_d;
      oval_q  <= oval_d;
    end
  end

  assign empty_o         = !oval_q;
  assign out_char_o      = ochar_q;
  assign last_of_run_o   = olast_q;
  assign emitted_total_o = ototal_q;

endmodule

>>> src/printf_style_formatter_top.sv
// ----------------------------------------------------------------------------
// printf_style_formatter_top
// Printf-style formatter: format bytes in, one ASCII character per result.
//
// Input queue: push_i/full_o with fmt_byte_i, arg_value_i, first_of_format_i.
// Result queue: empty_o/pop_i with out_char_o, last_of_run_o and
// emitted_total_o; the oldest result sits on the ports while empty_o is low.
// A front stage classifies each byte and tracks a pending '%'; a two-entry
// command queue decouples it from the back end, which runs one command at a
// time. A plain character is latched from the queue, then written to the
// result register. A numeric conversion first pushes its digits onto a stack
// (a divide-by-ten reciprocal multiply for decimal, a nibble shift for hex),
// then emits the prefix, if any, and the digits one character at a time.
// Bytes that emit nothing take no back-end time unless they start a format.
// When pop_i is held low the back end waits with one result in the output
// register, the command queue fills, and full_o rises. Reset empties both
// queues, clears the pending '%' and the emitted count.
// ----------------------------------------------------------------------------
module printf_style_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  fmt_byte_i,
  input  logic [63:0] arg_value_i,
  input  logic        first_of_format_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_char_o,
  output logic        last_of_run_o,
  output logic [31:0] emitted_total_o
);
  import psf_pkg::*;

  cmd_t f_cmd, b_cmd;
  logic f_push, q_full, q_empty, b_pop;

  psf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .q_full_i          (q_full),
    .fmt_byte_i        (fmt_byte_i),
    .arg_value_i       (arg_value_i),
    .first_of_format_i (first_of_format_i),
    .q_push_o          (f_push),
    .q_cmd_o           (f_cmd)
  );

  psf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .empty_o (q_empty),
    .data_o  (b_cmd)
  );

  psf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (b_cmd),
    .q_pop_o         (b_pop),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .out_char_o      (out_char_o),
    .last_of_run_o   (last_of_run_o),
    .emitted_total_o (emitted_total_o)
  );

  assign full_o = q_full;

endmodule

>>> src/psf_checker.sv
// ----------------------------------------------------------------------------
// psf_checker
// Port-level checks on the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module psf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty_o,
  input logic        pop_i,
  input logic [7:0]  out_char_o,
  input logic        last_of_run_o,
  input logic [31:0] emitted_total_o
);

  logic        mid_run_q;
  logic [31:0] prev_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_run_q    <= 1'b0;
      prev_total_q <= '0;
    end else if (pop_i && !empty_o) begin
      mid_run_q    <= !last_of_run_o;
      prev_total_q <= emitted_total_o;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_char_o) &&
      $stable(last_of_run_o) && $stable(emitted_total_o)))
    else $error("stalled result changed");

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && mid_run_q && prev_total_q != 32'hFFFF_FFFF) |->
      (emitted_total_o == prev_total_q + 32'd1))
    else $error("count not consecutive within a run");

  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (emitted_total_o != 32'd0))
    else $error("result with zero emitted count");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty_o)
    else $error("result present after reset");

endmodule

bind printf_style_formatter_top psf_checker u_psf_checker (.*);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the printf-style formatter.
//
// Format bytes go in through the push/full queue. A model of the pending '%'
// flag and the emitted count predicts every character, the last-of-run mark
// and the running total for each item that the block takes. A checker
// compares each popped result with the oldest prediction. The stimulus runs
// in this order: a directed set of conversions and corner cases, random
// format strings mixed with noise bytes, one long output stall that backs up
// the input, and a final stretch where neither side idles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psf_pkg::*;

  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles  = 150;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last_run;
    logic [31:0] total;
  } char_rec_t;

  typedef logic [7:0] text_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [7:0]  fmt_byte_i = '0;
  logic [63:0] arg_value_i = '0;
  logic        first_of_format_i = 1'b0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        last_of_run_o;
  logic [31:0] emitted_total_o;

  // outputs as seen just before the next rising edge
  logic        full_n = 1'b1;
  logic        empty_n = 1'b1;
  logic [7:0]  char_n;
  logic        last_n;
  logic [31:0] total_n;

  char_rec_t   expected_chars[$];
  logic        pct_pending = 1'b0;
  logic [31:0] emit_cnt = '0;

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned stuck = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;

  logic [7:0] sel_list [8] = '{SelC, SelD, SelI, SelU, SelX, SelUpX, SelP, ChPercent};

  printf_style_formatter_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .full_o            (full_o),
    .fmt_byte_i        (fmt_byte_i),
    .arg_value_i       (arg_value_i),
    .first_of_format_i (first_of_format_i),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .out_char_o        (out_char_o),
    .last_of_run_o     (last_of_run_o),
    .emitted_total_o   (emitted_total_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    full_n  = full_o;
    empty_n = empty_o;
    char_n  = out_char_o;
    last_n  = last_of_run_o;
    total_n = emitted_total_o;
  end

  // appends v in the given radix, most significant digit first
  function automatic text_t with_number(input text_t txt, input logic [63:0] v,
                                        input logic [63:0] radix, input bit upper);
    string       glyphs;
    logic [63:0] d;
    int          at;
    glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
    at = txt.size();
    do begin
      d = v % radix;
      txt.insert(at, glyphs[d[3:0]]);
      v = v / radix;
    end while (v != 0);
    return txt;
  endfunction

  task automatic format_byte(input logic [7:0] b, input logic [63:0] arg,
                             input logic fresh);
    text_t       txt;
    logic [31:0] lo;
    logic [31:0] mag;
    lo = arg[31:0];
    if (fresh) emit_cnt = '0;
    if (b == ChNul) begin
      pct_pending = 1'b0;
    end else if (pct_pending) begin
      pct_pending = 1'b0;
      case (b)
        SelC: txt.push_back(arg[7:0]);
        SelD, SelI: begin
          if (lo[31]) begin
            txt.push_back(ChMinus);
            mag = 32'd0 - lo;
            txt = with_number(txt, {32'd0, mag}, 64'd10, 1'b0);
          end else begin
            txt = with_number(txt, {32'd0, lo}, 64'd10, 1'b0);
          end
        end
        SelU:   txt = with_number(txt, {32'd0, lo}, 64'd10, 1'b0);
        SelX:   txt = with_number(txt, {32'd0, lo}, 64'd16, 1'b0);
        SelUpX: txt = with_number(txt, {32'd0, lo}, 64'd16, 1'b1);
        SelP: begin
          txt.push_back(ChZero);
          txt.push_back(ChLowX);
          txt = with_number(txt, arg, 64'd16, 1'b0);
        end
        ChPercent: txt.push_back(ChPercent);
        default: ;
      endcase
    end else if (b == ChPercent) begin
      pct_pending = 1'b1;
    end else begin
      txt.push_back(b);
    end
    foreach (txt[k]) begin
      if (emit_cnt != 32'hFFFF_FFFF) emit_cnt++;
      expected_chars.push_back(char_rec_t'{ch: txt[k], last_run: (k == txt.size() - 1),
                                           total: emit_cnt});
    end
  endtask

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20));
      2: return {$urandom, 1'b1, 31'($urandom)};
      3: return $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
      default: return {32'h0, $urandom};
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [63:0] arg,
                           input logic fresh);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push_i            <= 1'b1;
    fmt_byte_i        <= b;
    arg_value_i       <= arg;
    first_of_format_i <= fresh;
    do @(posedge clk_i); while (full_n);
    items_sent++;
    format_byte(b, arg, fresh);
  endtask

  task automatic send_conv(input logic [7:0] sel, input logic [63:0] arg);
    send_item(ChPercent, rand_arg(), 1'b0);
    send_item(sel, arg, 1'b0);
  endtask

  // one format string: plain bytes, conversions, now and then a broken one
  task automatic send_format();
    logic [7:0] b;
    logic       fresh;
    fresh = 1'b1;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          b = 8'($urandom_range(1, 255));
          if (b == ChPercent) b = ChLowX;
          send_item(b, rand_arg(), fresh);
        end
        9: begin
          send_item(ChPercent, rand_arg(), fresh);
          send_item(8'($urandom_range(0, 255)), rand_arg(), 1'b0);
        end
        default: begin
          send_item(ChPercent, rand_arg(), fresh);
          send_item(sel_list[$urandom_range(0, 7)], rand_arg(), 1'b0);
        end
      endcase
      fresh = 1'b0;
    end
    if ($urandom_range(0, 7) != 0) send_item(ChNul, rand_arg(), 1'b0);
  endtask

  task automatic test_directed();
    send_item(8'h41, rand_arg(), 1'b1);
    send_item(8'hFF, 64'h0, 1'b0);
    send_conv(ChPercent, 64'h0);
    send_conv(SelC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_conv(SelD, 64'h0000_0000_8000_0000);
    send_conv(SelI, 64'hFFFF_FFFF_0000_0000);
    send_conv(SelD, 64'h0000_0000_7FFF_FFFF);
    send_conv(SelU, 64'h1234_5678_FFFF_FFFF);
    send_conv(SelX, 64'h0000_0000_DEAD_BEEF);
    send_conv(SelUpX, 64'hFFFF_FFFF_ABCD_EF01);
    send_conv(SelP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_conv(SelP, 64'h0);
    send_conv(8'h71, 64'd7);
    send_conv(ChNul, 64'd1);
    // a '%' left open survives the start of the next format
    send_item(ChPercent, 64'h0, 1'b0);
    send_item(SelD, 64'd5, 1'b1);
    send_item(ChNul, 64'h0, 1'b0);
  endtask

  task automatic test_random_formats();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < 400) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), rand_arg(), 1'($urandom_range(0, 1)));
      end else begin
        send_format();
      end
    end
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (12) send_conv(SelP, rand_arg());
    send_item(ChNul, 64'h0, 1'b0);
  endtask

  task automatic test_streaming();
    int unsigned start;
    quiet = 1'b1;
    start = items_sent;
    while (items_sent - start < 40) send_format();
  endtask

  always @(posedge clk_i) begin
    char_rec_t want;
    if (rst_ni) begin
      if (pop_i && !empty_n) begin
        if (expected_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected result: char %h last %b total %0d",
                                  char_n, last_n, total_n));
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== char_n || want.last_run !== last_n || want.total !== total_n) begin
            note_mismatch($sformatf(
              "mismatch: expected char %h last %b total %0d, got char %h last %b total %0d",
              want.ch, want.last_run, want.total, char_n, last_n, total_n));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        pop_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        pop_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_n) || (pop_i && !empty_n)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= StuckLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_formats();
    test_output_stall();
    test_streaming();
    push_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
